// File: sv/bdtc_pkg.sv
// ----------------------------------------------------------------------------
// bdtc_pkg: shared types and constants
// Tap kinds, configuration register indices and the configuration bundle
// of the button debounce and tap classifier.
// ----------------------------------------------------------------------------
package bdtc_pkg;

  localparam int CFG_TICK_W = 10;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    TAP_SINGLE = 2'd0,
    TAP_DOUBLE = 2'd1,
    TAP_RAW    = 2'd2
  } tap_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_DOUBLE_TAP = 2'd1,
    CFG_COUNT_MODE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_TICK_W-1:0] debounce_ticks;
    logic [CFG_TICK_W-1:0] double_tap_ticks;
    logic                  count_mode;
  } cfg_t;

  typedef struct packed {
    logic      valid;
    tap_kind_t kind;
  } tap_result_t;

endpackage

// File: sv/tick_if.sv
// ----------------------------------------------------------------------------
// tick_if: tick channel
// Carries one millisecond tick word with the sampled button level.
// ----------------------------------------------------------------------------
interface tick_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// File: sv/tap_if.sv
// ----------------------------------------------------------------------------
// tap_if: tap result channel
// Carries one classified tap word.
// ----------------------------------------------------------------------------
interface tap_if;
  logic                        valid;
  logic                        ready;
  logic [bdtc_pkg::KIND_W-1:0] tap_kind;

  modport source (output valid, output tap_kind, input ready);
  modport sink   (input valid, input tap_kind, output ready);
endinterface

// File: sv/cfg_if.sv
// ----------------------------------------------------------------------------
// cfg_if: configuration write channel
// Carries a register index and the write data word.
// ----------------------------------------------------------------------------
interface cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bdtc_pkg::CFG_IDX_W-1:0]  index;
  logic [bdtc_pkg::CFG_TICK_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/bdtc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdtc_cfg_regs: configuration registers
// Holds debounce length, double-tap window and count mode.
// ----------------------------------------------------------------------------
module bdtc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [bdtc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bdtc_pkg::CFG_TICK_W-1:0] wr_data,
  output bdtc_pkg::cfg_t                  cfg
);
  import bdtc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= CFG_TICK_W'(30);
      cfg.double_tap_ticks <= CFG_TICK_W'(300);
      cfg.count_mode       <= 1'b0;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_DEBOUNCE:   cfg.debounce_ticks   <= wr_data;
        CFG_DOUBLE_TAP: cfg.double_tap_ticks <= wr_data;
        CFG_COUNT_MODE: cfg.count_mode       <= wr_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

// File: sv/bdtc_tap_core.sv
// ----------------------------------------------------------------------------
// bdtc_tap_core: debounce and tap classification
// Holds the debounce and window state and works out one tick per step.
// ----------------------------------------------------------------------------
module bdtc_tap_core #(
  parameter int TICK_COUNT_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  level,
  input  bdtc_pkg::cfg_t        cfg,
  output bdtc_pkg::tap_result_t result
);
  import bdtc_pkg::*;

  localparam int W  = TICK_COUNT_BITS;
  localparam int CW = (W > CFG_TICK_W) ? W : CFG_TICK_W;
  localparam logic [CW-1:0] CNT_MAX_EXT = CW'({W{1'b1}});

  logic         previous_level, previous_level_next;
  logic [W-1:0] debounce_left,  debounce_left_next;
  logic         debounce_armed, debounce_armed_next;
  logic         single_pending, single_pending_next;
  logic [W-1:0] since_release,  since_release_next;

  logic [CW-1:0] deb_ext, win_ext;
  logic [W-1:0]  deb_load, window;
  logic          pend_a;
  logic [W-1:0]  since_a;
  logic          released_now;

  // clamp register values to the counter range
  assign deb_ext  = CW'(cfg.debounce_ticks);
  assign win_ext  = CW'(cfg.double_tap_ticks);
  assign deb_load = (deb_ext > CNT_MAX_EXT) ? {W{1'b1}} : W'(deb_ext);
  assign window   = (win_ext > CNT_MAX_EXT) ? {W{1'b1}} : W'(win_ext);

  always_comb begin
    // advance the window timer at the start of the tick
    pend_a  = single_pending;
    since_a = since_release;
    if (cfg.count_mode) begin
      pend_a  = 1'b0;
      since_a = '0;
    end else if (single_pending && (since_release != {W{1'b1}})) begin
      since_a = since_release + W'(1);
    end

    previous_level_next = previous_level;
    debounce_left_next  = debounce_left;
    debounce_armed_next = debounce_armed;
    released_now        = 1'b0;
    if (level != previous_level) begin
      previous_level_next = level;
      debounce_left_next  = deb_load;
      debounce_armed_next = 1'b1;
    end else if (debounce_armed) begin
      if (debounce_left <= W'(1)) begin
        debounce_left_next  = '0;
        debounce_armed_next = 1'b0;
        released_now        = !level;
      end else begin
        debounce_left_next = debounce_left - W'(1);
      end
    end

    single_pending_next = pend_a;
    since_release_next  = since_a;
    result.valid        = 1'b0;
    result.kind         = TAP_SINGLE;
    if (released_now && cfg.count_mode) begin
      result.valid = 1'b1;
      result.kind  = TAP_RAW;
    end else if (released_now && pend_a && (since_a <= window)) begin
      single_pending_next = 1'b0;
      since_release_next  = '0;
      result.valid        = 1'b1;
      result.kind         = TAP_DOUBLE;
    end else begin
      if (released_now) begin
        single_pending_next = 1'b1;
        since_release_next  = '0;
      end
      // window expiry, checked after release classification
      if (single_pending_next && (since_release_next >= window)) begin
        single_pending_next = 1'b0;
        since_release_next  = '0;
        result.valid        = 1'b1;
        result.kind         = TAP_SINGLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      debounce_left  <= '0;
      debounce_armed <= 1'b0;
      single_pending <= 1'b0;
      since_release  <= '0;
    end else if (step) begin
      previous_level <= previous_level_next;
      debounce_left  <= debounce_left_next;
      debounce_armed <= debounce_armed_next;
      single_pending <= single_pending_next;
      since_release  <= since_release_next;
    end
  end

  a_count_mode_clears: assert property (@(posedge clk) disable iff (rst)
    (step && cfg.count_mode) |=> !single_pending)
    else $error("pending tap survived a count mode tick");

  a_since_only_pending: assert property (@(posedge clk) disable iff (rst)
    (since_release != '0) |-> single_pending)
    else $error("window timer running with nothing pending");

  a_left_only_armed: assert property (@(posedge clk) disable iff (rst)
    (debounce_left != '0) |-> debounce_armed)
    else $error("debounce count left behind while not armed");

endmodule

// File: sv/button_debounce_tap_classifier_core.sv
// Order: a tick word is taken into the input register, then classified into
// the result register when that register can advance, where its tap word is
// offered and held while the sink stalls. Throughput: one tick word per cycle
// unless the sink stalls; a waiting result does not block intake while the
// result register is being drained. Only small counters update.
// Reset (rst, synchronous): registers return to their defaults, state clears.
// ----------------------------------------------------------------------------
// button_debounce_tap_classifier_core: top level
// Debounces the button level and reports single, double or raw taps.
// ----------------------------------------------------------------------------
module button_debounce_tap_classifier_core #(
  parameter int TICK_COUNT_BITS = 10
) (
  input logic   clk,
  input logic   rst,
  tick_if.sink  tick,
  tap_if.source tap,
  cfg_if.sink   cfg
);
  import bdtc_pkg::*;

  cfg_t        cfg_regs;
  tap_result_t result;

  logic        s1_valid;
  logic        s1_level;
  logic        out_valid;
  tap_kind_t   out_kind;
  logic        advance;

  assign cfg.ready  = 1'b1;
  assign advance    = !out_valid || tap.ready;
  assign tick.ready = !s1_valid || advance;

  bdtc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  bdtc_tap_core #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_valid && advance),
    .level  (s1_level),
    .cfg    (cfg_regs),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      s1_level <= tick.pin_level;
    end
  end

  // result register: hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind <= result.kind;
    end
  end

  assign tap.valid    = out_valid;
  assign tap.tap_kind = out_kind;

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("tap word without a tick word behind it");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("stalled tick word lost");

  a_no_intake_on_stall: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !tap.ready) |-> !tick.ready)
    else $error("tick taken while both stages are full and stalled");

endmodule
